// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check: consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// concurrent check: consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/abs_pkg.sv =====
`timescale 1ns / 1ps

package abs_pkg;

  localparam int UTC_W      = 32;
  localparam int SPEED_W    = 8;
  localparam int HEADING_W  = 9;
  localparam int INTERVAL_W = 24;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam int DIV_STEPS  = INTERVAL_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [HEADING_W-1:0]  HALF_TURN    = 9'd180;
  localparam logic [HEADING_W-1:0]  FULL_TURN    = 9'd360;
  localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = 24'hFFFFFF;

  // register indexes (word address bits)
  localparam logic [2:0] REG_LOW_SPEED      = 3'd0;
  localparam logic [2:0] REG_HIGH_SPEED     = 3'd1;
  localparam logic [2:0] REG_STOP_INTERVAL  = 3'd2;
  localparam logic [2:0] REG_FAST_INTERVAL  = 3'd3;
  localparam logic [2:0] REG_MIN_TURN_TIME  = 3'd4;
  localparam logic [2:0] REG_TURN_LIMIT     = 3'd5;

  localparam logic [7:0]  RST_LOW_SPEED      = 8'd5;
  localparam logic [7:0]  RST_HIGH_SPEED     = 8'd60;
  localparam logic [15:0] RST_STOP_INTERVAL  = 16'd1800;
  localparam logic [15:0] RST_FAST_INTERVAL  = 16'd90;
  localparam logic [15:0] RST_MIN_TURN_TIME  = 16'd15;
  localparam logic [15:0] RST_TURN_LIMIT     = 16'd255;

  typedef struct packed {
    logic [7:0]  low_speed;
    logic [7:0]  high_speed;
    logic [15:0] stop_interval;
    logic [15:0] fast_interval;
    logic [15:0] min_turn_time;
    logic [15:0] turn_limit;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic eval;
    logic turn;
    logic div_step;
    logic finish;
  } cmd_t;

endpackage

// ===== sv/abs_if.sv =====
`timescale 1ns / 1ps

interface abs_tick_if;
  logic        valid;
  logic        ready;
  logic [31:0] utc_seconds;
  logic        fix_valid;
  logic [7:0]  speed_mph;
  logic [8:0]  heading_deg;

  modport source (output valid, output utc_seconds, output fix_valid,
                  output speed_mph, output heading_deg, input ready);
  modport sink (input valid, input utc_seconds, input fix_valid,
                input speed_mph, input heading_deg, output ready);
endinterface

interface abs_result_if;
  logic        valid;
  logic        ready;
  logic        send_beacon;
  logic        turn_triggered;
  logic [23:0] interval_seconds;

  modport source (output valid, output send_beacon, output turn_triggered,
                  output interval_seconds, input ready);
  modport sink (input valid, input send_beacon, input turn_triggered,
                input interval_seconds, output ready);
endinterface

// ===== sv/abs_ctrl.sv =====
`timescale 1ns / 1ps

module abs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output abs_pkg::cmd_t cmd
);
  import abs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_EVAL,
    S_TURN,
    S_DIV,
    S_FINISH
  } state_t;

  state_t               state;
  logic [DIV_CNT_W-1:0] count;
  logic                 can_load_out;

  assign in_ready     = (state == S_IDLE);
  assign can_load_out = !out_valid || out_ready;

  assign cmd.load     = (state == S_IDLE) && in_valid;
  assign cmd.prep     = (state == S_PREP);
  assign cmd.eval     = (state == S_EVAL);
  assign cmd.turn     = (state == S_TURN);
  assign cmd.div_step = (state == S_DIV);
  assign cmd.finish   = (state == S_FINISH) && can_load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_PREP;
          end
        end
        S_PREP: state <= S_EVAL;
        S_EVAL: state <= S_TURN;
        S_TURN: begin
          count <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          count <= count + 1'b1;
          if (count == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // result register frees up in the same cycle it is taken
          if (can_load_out) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/abs_dp.sv =====
`timescale 1ns / 1ps

module abs_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  abs_pkg::cmd_t                       cmd,
  input  abs_pkg::cfg_t                       cfg,
  input  logic [abs_pkg::UTC_W-1:0]           utc_seconds,
  input  logic                                fix_valid,
  input  logic [abs_pkg::SPEED_W-1:0]         speed_mph,
  input  logic [abs_pkg::HEADING_W-1:0]       heading_deg,
  output logic                                send_beacon,
  output logic                                turn_triggered,
  output logic [abs_pkg::INTERVAL_W-1:0]      interval_seconds
);
  import abs_pkg::*;

  logic [UTC_W-1:0]      utc_r;
  logic                  item_ok;
  logic [SPEED_W-1:0]    speed_r;
  logic [HEADING_W-1:0]  heading_r;

  logic [UTC_W-1:0]      last_time;
  logic [HEADING_W-1:0]  last_heading;

  logic [UTC_W-1:0]      elapsed_r;
  logic [7:0]            change_r;
  logic                  change_ok;
  logic                  turn_r;

  logic [INTERVAL_W-1:0] quot;
  logic [SPEED_W-1:0]    rem;

  logic [UTC_W-1:0]      elapsed;
  logic [HEADING_W-1:0]  diff_abs;
  logic [HEADING_W-1:0]  folded;
  logic [15:0]           turn_prod;
  logic [SPEED_W:0]      rem_sh;
  logic                  rem_fits;
  logic                  slow;
  logic [INTERVAL_W-1:0] interval;
  logic                  turn_eff;
  logic                  send;

  assign elapsed = utc_r - last_time;

  assign diff_abs = (last_heading >= heading_r) ? (last_heading - heading_r)
                                                : (heading_r - last_heading);
  assign folded   = FULL_TURN - diff_abs;

  assign turn_prod = change_r * speed_r;

  assign rem_sh   = {rem, quot[INTERVAL_W-1]};
  assign rem_fits = (rem_sh >= {1'b0, speed_r});

  assign slow = (speed_r < cfg.low_speed);

  always_comb begin
    if (slow) begin
      interval = {8'd0, cfg.stop_interval};
    end else if (speed_r > cfg.high_speed) begin
      interval = {8'd0, cfg.fast_interval};
    end else if (speed_r == '0) begin
      interval = INTERVAL_MAX;
    end else begin
      interval = quot;
    end
  end

  assign turn_eff = turn_r && !slow;
  assign send     = (elapsed_r > {8'd0, interval}) || turn_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time    <= '0;
      last_heading <= '0;
    end else begin
      if (cmd.prep && item_ok && (elapsed < {16'd0, cfg.min_turn_time})) begin
        last_heading <= heading_r;
      end
      if (cmd.finish && item_ok && send) begin
        last_time    <= utc_r;
        last_heading <= heading_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      utc_r     <= utc_seconds;
      item_ok   <= (utc_seconds != '0) && fix_valid;
      speed_r   <= speed_mph;
      heading_r <= heading_deg;
    end
    if (cmd.prep) begin
      elapsed_r <= elapsed;
    end
    if (cmd.eval) begin
      // fold the heading change to the short way round
      if (diff_abs <= HALF_TURN) begin
        change_r  <= diff_abs[7:0];
        change_ok <= (diff_abs != '0);
      end else if (diff_abs < FULL_TURN) begin
        change_r  <= folded[7:0];
        change_ok <= 1'b1;
      end else begin
        change_r  <= '0;
        change_ok <= 1'b0;
      end
      quot <= cfg.fast_interval * cfg.high_speed;
      rem  <= '0;
    end
    if (cmd.turn) begin
      turn_r <= change_ok && (speed_r != '0) && (turn_prod > cfg.turn_limit) &&
                (elapsed_r > {16'd0, cfg.min_turn_time});
    end
    if (cmd.div_step) begin
      // restoring division, one quotient bit per cycle
      if (rem_fits) begin
        rem <= SPEED_W'(rem_sh - {1'b0, speed_r});
      end else begin
        rem <= rem_sh[SPEED_W-1:0];
      end
      quot <= {quot[INTERVAL_W-2:0], rem_fits};
    end
    if (cmd.finish) begin
      if (item_ok) begin
        send_beacon      <= send;
        turn_triggered   <= turn_eff;
        interval_seconds <= interval;
      end else begin
        send_beacon      <= 1'b0;
        turn_triggered   <= 1'b0;
        interval_seconds <= '0;
      end
    end
  end

endmodule

// ===== sv/adaptive_beacon_scheduler.sv =====
`timescale 1ns / 1ps
// each tick runs prep, eval, turn, then the 24-step restoring divider (one
// quotient bit per cycle) that works out fast_interval*high_speed/speed, then
// finish, which waits for a free result register; no new tick until back in idle
// reset: synchronous, active high; clears last beacon time and heading to zero,
// loads the register defaults and empties the result register; no clearing pass

`include "assert_macros.svh"

module adaptive_beacon_scheduler (
  input  logic                        clk,
  input  logic                        rst,
  abs_tick_if.sink                    tick,
  abs_result_if.source                result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [abs_pkg::ADDR_W-1:0]  paddr,
  input  logic [abs_pkg::DATA_W-1:0]  pwdata,
  output logic [abs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import abs_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_speed      <= RST_LOW_SPEED;
      cfg.high_speed     <= RST_HIGH_SPEED;
      cfg.stop_interval  <= RST_STOP_INTERVAL;
      cfg.fast_interval  <= RST_FAST_INTERVAL;
      cfg.min_turn_time  <= RST_MIN_TURN_TIME;
      cfg.turn_limit     <= RST_TURN_LIMIT;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LOW_SPEED:      cfg.low_speed      <= pwdata[7:0];
        REG_HIGH_SPEED:     cfg.high_speed     <= pwdata[7:0];
        REG_STOP_INTERVAL:  cfg.stop_interval  <= pwdata[15:0];
        REG_FAST_INTERVAL:  cfg.fast_interval  <= pwdata[15:0];
        REG_MIN_TURN_TIME:  cfg.min_turn_time  <= pwdata[15:0];
        REG_TURN_LIMIT:     cfg.turn_limit     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LOW_SPEED:      prdata = {24'd0, cfg.low_speed};
      REG_HIGH_SPEED:     prdata = {24'd0, cfg.high_speed};
      REG_STOP_INTERVAL:  prdata = {16'd0, cfg.stop_interval};
      REG_FAST_INTERVAL:  prdata = {16'd0, cfg.fast_interval};
      REG_MIN_TURN_TIME:  prdata = {16'd0, cfg.min_turn_time};
      REG_TURN_LIMIT:     prdata = {16'd0, cfg.turn_limit};
      default:            prdata = '0;
    endcase
  end

  abs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick.valid),
    .in_ready  (tick.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  abs_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg              (cfg),
    .utc_seconds      (tick.utc_seconds),
    .fix_valid        (tick.fix_valid),
    .speed_mph        (tick.speed_mph),
    .heading_deg      (tick.heading_deg),
    .send_beacon      (result.send_beacon),
    .turn_triggered   (result.turn_triggered),
    .interval_seconds (result.interval_seconds)
  );

  // one tick in flight at a time
  `ASSERT_NEXT(a_one_in_flight, clk, rst, tick.valid && tick.ready, !tick.ready, "second tick accepted while busy")
  // a turn beacon always goes out
  `ASSERT_SAME(a_turn_sends, clk, rst, result.valid && result.turn_triggered, result.send_beacon, "turn without beacon")
  // a new result only appears at the end of a computation
  `ASSERT_SAME(a_result_after_work, clk, rst, $rose(result.valid), $past(!tick.ready), "result without work")

endmodule
